[hw/rtl/dcu_pkg.sv]
// Shared types, constants and register indexes for the delay-based cwnd update block.
// No dependencies; used by dcu_mul, dcu_div and delay_based_cwnd_update_unit.

package dcu_pkg;

  localparam int FRACTION_BITS_DEF = 16;

  // Divider: widest dividend is alpha*acked*seg*seg (56 bits) or diff << FRACTION_BITS.
  localparam int DIVIDEND_W = 56;
  localparam int DIVISOR_W  = 32;
  localparam int MUL_W      = 32;

  localparam logic [31:0] NS_PER_MS       = 32'd1000000;
  localparam logic [31:0] FIXED_TARGET_NS = 32'd25000000;
  localparam logic [31:0] NS_PER_S        = 32'd1000000000;

  // Target delay modes
  localparam logic [1:0] TGT_BASE     = 2'd0;
  localparam logic [1:0] TGT_BASE_1MS = 2'd1;

  // Request actions
  localparam logic ACT_RTT_SAMPLE = 1'b0;

  // Configuration register indexes
  localparam logic [2:0] CFG_ADDITIVE_GAIN = 3'd0;
  localparam logic [2:0] CFG_DECREASE_GAIN = 3'd1;
  localparam logic [2:0] CFG_TARGET_MODE   = 3'd2;
  localparam logic [2:0] CFG_MAX_DECREASE  = 3'd3;
  localparam logic [2:0] CFG_SEGMENT_BYTES = 3'd4;
  localparam logic [2:0] CFG_MIN_WINDOW    = 3'd5;
  localparam logic [2:0] CFG_MAX_WINDOW    = 3'd6;
  localparam logic [2:0] CFG_MAX_PACING    = 3'd7;

  typedef struct packed {
    logic        action;
    logic [31:0] rtt_sample_ns;
    logic [31:0] last_rtt_ns;
    logic [15:0] acked_segments;
    logic [31:0] window_bytes;
    logic        decrease_allowed;
  } in_req_t;

  typedef struct packed {
    logic [31:0] new_window_bytes;
    logic [36:0] pacing_bps;
    logic        decrease_mark;
    logic [31:0] base_rtt_ns;
  } out_rsp_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

[hw/rtl/dcu_mul.sv]
// Shared 32x32 multiplier with a registered 64-bit product.
// Depends on dcu_pkg.

module dcu_mul (
  input  logic                     clk_i,
  input  logic [dcu_pkg::MUL_W-1:0] a_i,
  input  logic [dcu_pkg::MUL_W-1:0] b_i,
  output logic [2*dcu_pkg::MUL_W-1:0] p_o
);
  import dcu_pkg::*;

  logic [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

[hw/rtl/dcu_div.sv]
// Serial restoring divider, one quotient bit per cycle.
// Depends on dcu_pkg (div_req_t, div_rsp_t, widths).

module dcu_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dcu_pkg::div_req_t div_req_i,
  output dcu_pkg::div_rsp_t div_rsp_o
);
  import dcu_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVISOR_W:0]    rem_q, rem_d, rem_sh;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic                  ge;

  assign rem_sh = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (div_req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = div_req_i.dividend;
      dvs_d  = div_req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign div_rsp_o.done     = done_q;
  assign div_rsp_o.quotient = quo_q;

endmodule

[hw/rtl/delay_based_cwnd_update_unit.sv]
// Top level of the delay-based congestion window update block.
// Depends on dcu_pkg, dcu_mul (shared multiplier) and dcu_div (serial divider).
//
// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+------------------------------
// in      | input     | in_valid_i / in_stall_o | in_req_i  (dcu_pkg::in_req_t)
// out     | output    | out_valid_o/ out_stall_i| out_rsp_o (dcu_pkg::out_rsp_t)
// cfg     | input     | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// One request at a time. An RTT-sample request goes from S_IDLE straight to
// S_OUT and on into the output register. A window request needs no divider
// pass when the decrease is blocked and no pacing division is due, and at
// most two otherwise (increase quotient or decrease fraction, then the pacing
// rate below one segment); each division is one serial divider pass. Reset
// clears the sequencer, the base RTT (all ones) and the configuration
// registers to their defaults. A finished result waits in the output register
// under out_stall_i while the next request is already accepted; the sequencer
// holds in S_OUT only while that register is full and out_stall_i is set.

module delay_based_cwnd_update_unit #(
  parameter int FRACTION_BITS = dcu_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dcu_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dcu_pkg::out_rsp_t out_rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [36:0]       cfg_data_i
);
  import dcu_pkg::*;

  localparam logic [FRACTION_BITS:0] ONE_Q = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_CMP    = 15'b000000000000010,
    S_INC_A  = 15'b000000000000100,
    S_INC_B  = 15'b000000000001000,
    S_INC_C  = 15'b000000000010000,
    S_INC_D  = 15'b000000000100000,
    S_INC_E  = 15'b000000001000000,
    S_ADD    = 15'b000000010000000,
    S_DEC_Q  = 15'b000000100000000,
    S_DEC_F  = 15'b000001000000000,
    S_DEC_W  = 15'b000010000000000,
    S_CLAMP  = 15'b000100000000000,
    S_PACE_M = 15'b001000000000000,
    S_PACE_D = 15'b010000000000000,
    S_OUT    = 15'b100000000000000
  } state_e;

  // configuration
  logic [7:0]  alpha_q, beta_q;
  logic [1:0]  mode_q;
  logic [15:0] mdq_q, seg_cfg_q;
  logic [31:0] min_win_q, max_win_q;
  logic [36:0] max_pace_q;

  // sequencer and datapath
  state_e      state_q, state_d;
  in_req_t     req_q, req_d;
  logic [31:0] min_rtt_q, min_rtt_d;
  logic [15:0] seg_q, seg_d;
  logic [31:0] nw_q, nw_d;
  logic [DIVIDEND_W-1:0] val_q, val_d;
  logic [23:0] p1_q, p1_d;
  logic [36:0] pace_q, pace_d;
  out_rsp_t    out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_q;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic        accept;
  logic [32:0] target;
  logic        below;
  logic [31:0] diff;
  logic [16+FRACTION_BITS-1:0] mdq_sh;
  logic [FRACTION_BITS:0] v2, one_m_d, factor;
  logic [DIVIDEND_W:0] sum;
  logic [31:0] clamp_lo, clamp;
  logic [31:0] pace_div;

  dcu_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_q)
  );

  dcu_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .div_req_i (div_req),
    .div_rsp_o (div_rsp)
  );

  assign in_stall_o  = state_q != S_IDLE;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // target delay: the kept base RTT, the base RTT plus 1 ms, or a fixed 25 ms
  always_comb begin
    unique case (mode_q)
      TGT_BASE:     target = {1'b0, min_rtt_q};
      TGT_BASE_1MS: target = {1'b0, min_rtt_q} + {1'b0, NS_PER_MS};
      default:      target = {1'b0, FIXED_TARGET_NS};
    endcase
  end

  assign below = {1'b0, req_q.last_rtt_ns} < target;
  assign diff  = req_q.last_rtt_ns - target[31:0];

  // floor of the largest decrease fraction, then 1 - it; factor is 1 - decrease, never below that
  assign mdq_sh  = {mdq_q, {FRACTION_BITS{1'b0}}};
  assign v2      = ONE_Q - (FRACTION_BITS+1)'(mdq_sh[16+FRACTION_BITS-1:16]);
  assign one_m_d = ONE_Q - mul_q[FRACTION_BITS:0];
  assign factor  = (mul_q < (2*MUL_W)'(ONE_Q) && one_m_d > v2) ? one_m_d : v2;

  assign sum = {1'b0, DIVIDEND_W'(req_q.window_bytes)} + {1'b0, val_q};

  assign clamp_lo = (nw_q < min_win_q) ? min_win_q : nw_q;
  assign clamp    = (clamp_lo > max_win_q) ? max_win_q : clamp_lo;
  assign pace_div = (req_q.last_rtt_ns < NS_PER_MS) ? NS_PER_MS : req_q.last_rtt_ns;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    min_rtt_d   = min_rtt_q;
    seg_d       = seg_q;
    nw_d        = nw_q;
    val_d       = val_q;
    p1_d        = p1_q;
    pace_d      = pace_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = in_req_i;
          seg_d = (seg_cfg_q == '0) ? 16'd1 : seg_cfg_q;
          if (in_req_i.action == ACT_RTT_SAMPLE) begin
            // zero means no sample
            if (in_req_i.rtt_sample_ns != '0 && in_req_i.rtt_sample_ns < min_rtt_q) begin
              min_rtt_d = in_req_i.rtt_sample_ns;
            end
            nw_d    = in_req_i.window_bytes;
            pace_d  = '0;
            state_d = S_OUT;
          end else begin
            state_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (below) begin
          mul_a   = MUL_W'(req_q.acked_segments);
          mul_b   = MUL_W'(alpha_q);
          state_d = S_INC_A;
        end else if (!req_q.decrease_allowed) begin
          nw_d    = req_q.window_bytes;
          state_d = S_CLAMP;
        end else if (req_q.last_rtt_ns == '0) begin
          // no decrease: beta * 0
          mul_b   = MUL_W'(beta_q);
          state_d = S_DEC_F;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIVIDEND_W'({diff, {FRACTION_BITS{1'b0}}});
          div_req.divisor  = req_q.last_rtt_ns;
          state_d          = S_DEC_Q;
        end
      end
      S_INC_A: begin
        p1_d = mul_q[23:0];
        if (req_q.window_bytes >= 32'(seg_q)) begin
          mul_a   = MUL_W'(seg_q);
          mul_b   = MUL_W'(seg_q);
          state_d = S_INC_B;
        end else begin
          mul_a   = MUL_W'(mul_q[23:0]);
          mul_b   = MUL_W'(seg_q);
          state_d = S_INC_E;
        end
      end
      S_INC_B: begin
        mul_a   = MUL_W'(p1_q);
        mul_b   = mul_q[MUL_W-1:0];
        state_d = S_INC_C;
      end
      S_INC_C: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_q[DIVIDEND_W-1:0];
        div_req.divisor  = req_q.window_bytes;
        state_d          = S_INC_D;
      end
      S_INC_D: begin
        if (div_rsp.done) begin
          val_d   = div_rsp.quotient;
          state_d = S_ADD;
        end
      end
      S_INC_E: begin
        val_d   = mul_q[DIVIDEND_W-1:0];
        state_d = S_ADD;
      end
      S_ADD: begin
        nw_d    = (|sum[DIVIDEND_W:32]) ? '1 : sum[31:0];
        state_d = S_CLAMP;
      end
      S_DEC_Q: begin
        if (div_rsp.done) begin
          mul_a   = MUL_W'(div_rsp.quotient[FRACTION_BITS:0]);
          mul_b   = MUL_W'(beta_q);
          state_d = S_DEC_F;
        end
      end
      S_DEC_F: begin
        mul_a   = MUL_W'(factor);
        mul_b   = req_q.window_bytes;
        state_d = S_DEC_W;
      end
      S_DEC_W: begin
        nw_d    = mul_q[FRACTION_BITS+31:FRACTION_BITS];
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        // upper clamp applied last so it wins when min > max
        nw_d = clamp;
        if (clamp < 32'(seg_q)) begin
          mul_a   = MUL_W'(clamp[15:0]);
          mul_b   = NS_PER_S;
          state_d = S_PACE_M;
        end else begin
          pace_d  = max_pace_q;
          state_d = S_OUT;
        end
      end
      S_PACE_M: begin
        div_req.start    = 1'b1;
        div_req.dividend = {mul_q[DIVIDEND_W-4:0], 3'b000};
        div_req.divisor  = pace_div;
        state_d          = S_PACE_D;
      end
      S_PACE_D: begin
        if (div_rsp.done) begin
          pace_d  = div_rsp.quotient[36:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.new_window_bytes = nw_q;
          out_d.pacing_bps       = pace_q;
          out_d.decrease_mark    = (req_q.action != ACT_RTT_SAMPLE) &&
                                   (nw_q <= req_q.window_bytes);
          out_d.base_rtt_ns      = min_rtt_q;
          out_valid_d            = 1'b1;
          state_d                = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      min_rtt_q   <= '1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      min_rtt_q   <= min_rtt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    seg_q  <= seg_d;
    nw_q   <= nw_d;
    val_q  <= val_d;
    p1_q   <= p1_d;
    pace_q <= pace_d;
    out_q  <= out_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= 8'd2;
      beta_q     <= 8'd4;
      mode_q     <= 2'd1;
      mdq_q      <= 16'd32768;
      seg_cfg_q  <= 16'd1448;
      min_win_q  <= 32'd1;
      max_win_q  <= '1;
      max_pace_q <= 37'd100000000000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ADDITIVE_GAIN: alpha_q    <= cfg_data_i[7:0];
        CFG_DECREASE_GAIN: beta_q     <= cfg_data_i[7:0];
        CFG_TARGET_MODE:   mode_q     <= cfg_data_i[1:0];
        CFG_MAX_DECREASE:  mdq_q      <= cfg_data_i[15:0];
        CFG_SEGMENT_BYTES: seg_cfg_q  <= cfg_data_i[15:0];
        CFG_MIN_WINDOW:    min_win_q  <= cfg_data_i[31:0];
        CFG_MAX_WINDOW:    max_win_q  <= cfg_data_i[31:0];
        CFG_MAX_PACING:    max_pace_q <= cfg_data_i;
        default:           ;
      endcase
    end
  end

endmodule
